/* src/tmr_pkg.sv */
package tmr_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START_ONCE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_START_PER  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STOP       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DISABLE    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RESTART    = 3'd5;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUSY = 2'd1;
  localparam logic [STAT_W-1:0] ST_IDLE = 2'd2;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd3;

  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] reload;
  } slot_rec_t;

  typedef struct packed {
    logic              fire;
    logic [STAT_W-1:0] status;
  } slot_evt_t;

  // low SLOT_W bits of a slot index, zero-extended when the index is narrower
  function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
    logic [SLOT_W+IDX_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

/* src/tmr_cell.sv */
module tmr_cell
  import tmr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift_en,
  input  slot_rec_t rec_in,
  output slot_rec_t rec_out
);

  slot_rec_t rec_r;
  slot_rec_t rec_nxt;

  always_comb begin
    rec_nxt = shift_en ? rec_in : rec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_out = rec_r;

endmodule

/* src/tmr_slot_alu.sv */
module tmr_slot_alu
  import tmr_pkg::*;
(
  input  logic [REQ_W-1:0] req,
  input  logic             hit,
  input  logic [CNT_W-1:0] ticks,
  input  slot_rec_t        rec_in,
  output slot_rec_t        rec_out,
  output slot_evt_t        evt
);

  logic [CNT_W-1:0] dec;
  logic             tick_zero;

  assign dec       = rec_in.cnt - CNT_W'(1);
  assign tick_zero = (ticks == '0);

  always_comb begin
    rec_out    = rec_in;
    evt.fire   = 1'b0;
    evt.status = ST_OK;
    if (req == REQ_TICK) begin
      if (rec_in.active) begin
        rec_out.cnt = dec;
        if (dec == '0) begin
          evt.fire = 1'b1;
          if (rec_in.reload != '0) begin
            rec_out.cnt = rec_in.reload;
          end else begin
            rec_out = '0;
          end
        end
      end
    end else if (!hit) begin
      evt.status = ST_IDLE;
    end else begin
      case (req)
        REQ_START_ONCE, REQ_START_PER: begin
          if (rec_in.active) begin
            evt.status = ST_BUSY;
          end else if (tick_zero) begin
            evt.status = ST_ZERO;
          end else begin
            rec_out.active = 1'b1;
            rec_out.cnt    = ticks;
            rec_out.reload = (req == REQ_START_PER) ? ticks : '0;
          end
        end
        REQ_STOP: begin
          if (!rec_in.active) begin
            evt.status = ST_IDLE;
          end else begin
            rec_out = '0;
          end
        end
        REQ_DISABLE: begin
          if (rec_in.active) begin
            rec_out.reload = '0;
          end
        end
        REQ_RESTART: begin
          if (!rec_in.active) begin
            evt.status = ST_IDLE;
          end else if (tick_zero) begin
            evt.status = ST_ZERO;
          end else begin
            rec_out.cnt = ticks;
          end
        end
        default: begin
          // query and unused codes report only
        end
      endcase
    end
  end

endmodule

/* src/software_timer_bank.sv */
// Bank of NUM_SLOTS timer slots held in a ring of cells that rotates one slot
// per cycle past a single update unit. Each request is taken with in_tready
// high only while the bank is idle; it then rotates the ring once (the
// addressed slot is updated as it passes, a tick updates every slot). A
// non-tick request then gives one result through the output register. A tick
// then scans its fire flags one slot per cycle while the output register is
// free, giving one result per fired slot in slot order (or one result when
// nothing fired). Results sit in an output register, so the next request can
// be accepted while the last result waits.
module software_timer_bank
  import tmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // slot_id[3:0], tick_count[35:4], zero pad
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // fired_slot[3:0], status[5:4],
                                  // slot_active[6], any_active[7]
  output logic        out_tuser,  // fired
  output logic        out_tlast
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  localparam int CMP_W = SLOT_W + IDX_W;

  logic [1:0]           state_r, state_nxt;
  logic [REQ_W-1:0]     req_r, req_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [CNT_W-1:0]     ticks_r, ticks_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0] fired_r, fired_nxt;
  logic [NUM_SLOTS-1:0] act_r, act_nxt;
  logic                 any_r, any_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic                 sact_r, sact_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r, out_data_nxt;
  logic                 out_user_r, out_user_nxt;
  logic                 out_last_r, out_last_nxt;

  slot_rec_t            cell_q [NUM_SLOTS];
  slot_rec_t            alu_rec;
  slot_evt_t            alu_evt;
  logic                 shift_en;
  logic                 hit;
  logic                 out_free;
  logic [NUM_SLOTS-1:0] rest;

  assign shift_en = (state_r == S_SWEEP);
  assign hit      = (req_r != REQ_TICK) && (CMP_W'(slot_r) == CMP_W'(idx_r));
  assign out_free = !out_valid_r || out_tready;
  assign rest     = (fired_r >> idx_r) >> 1;

  genvar k;
  generate
    for (k = 0; k < NUM_SLOTS; k++) begin : g_ring
      if (k == NUM_SLOTS - 1) begin : g_tail
        tmr_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .rec_in   (alu_rec),
          .rec_out  (cell_q[k])
        );
      end else begin : g_body
        tmr_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .rec_in   (cell_q[k+1]),
          .rec_out  (cell_q[k])
        );
      end
    end
  endgenerate

  // head of the ring is always the slot numbered idx_r during a sweep
  tmr_slot_alu u_alu (
    .req     (req_r),
    .hit     (hit),
    .ticks   (ticks_r),
    .rec_in  (cell_q[0]),
    .rec_out (alu_rec),
    .evt     (alu_evt)
  );

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    slot_nxt      = slot_r;
    ticks_nxt     = ticks_r;
    idx_nxt       = idx_r;
    fired_nxt     = fired_r;
    act_nxt       = act_r;
    any_nxt       = any_r;
    status_nxt    = status_r;
    sact_nxt      = sact_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt    = in_tuser;
          slot_nxt   = in_tdata[3:0];
          ticks_nxt  = in_tdata[35:4];
          idx_nxt    = '0;
          fired_nxt  = '0;
          act_nxt    = '0;
          any_nxt    = 1'b0;
          status_nxt = ST_IDLE;   // stays so when no slot matches
          sact_nxt   = 1'b0;
          state_nxt  = S_SWEEP;
        end
      end
      S_SWEEP: begin
        fired_nxt[idx_r] = alu_evt.fire;
        act_nxt[idx_r]   = alu_rec.active;
        any_nxt          = any_r | alu_rec.active;
        if (hit) begin
          status_nxt = alu_evt.status;
          sact_nxt   = alu_rec.active;
        end
        if (idx_r == IDX_W'(NUM_SLOTS - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (req_r != REQ_TICK) begin
            out_valid_nxt = 1'b1;
            out_user_nxt  = 1'b0;
            out_data_nxt  = {any_r, sact_r, status_r, {SLOT_W{1'b0}}};
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end else if (fired_r == '0) begin
            out_valid_nxt = 1'b1;
            out_user_nxt  = 1'b0;
            out_data_nxt  = {any_r, 1'b0, ST_OK, {SLOT_W{1'b0}}};
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end else if (fired_r[idx_r]) begin
            out_valid_nxt = 1'b1;
            out_user_nxt  = 1'b1;
            out_data_nxt  = {any_r, act_r[idx_r], ST_OK, idx_to_slot(idx_r)};
            out_last_nxt  = (rest == '0);
            if (rest == '0) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    slot_r     <= slot_nxt;
    ticks_r    <= ticks_nxt;
    idx_r      <= idx_nxt;
    fired_r    <= fired_nxt;
    act_r      <= act_nxt;
    any_r      <= any_nxt;
    status_r   <= status_nxt;
    sact_r     <= sact_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tmr_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;  // undefined code, acts as a query
  localparam int N_DIR      = 25;
  localparam int N_RAND     = 125;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;

  typedef enum logic [1:0] {PH_FREE, PH_SND_IDLE, PH_RCV_STALL, PH_BOTH} idle_mode_t;

  typedef struct packed {
    logic              fired;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
    logic              slot_act;
    logic              any_act;
    logic              last;
  } tmr_resp_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [SLOT_W-1:0] sid;
    logic [CNT_W-1:0]  ticks;
    logic              fixed_exp;  // expected response is written in the row
    tmr_resp_t         want;
  } req_row_t;

  localparam tmr_resp_t NO_CHECK = '0;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // slot_id[3:0], tick_count[35:4], zero pad
  logic [2:0]  in_tuser   = '0;   // req_type[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // fired_slot[3:0], status[5:4], slot_active[6],
                                  // any_active[7]
  logic        out_tuser;         // fired
  logic        out_tlast;

  software_timer_bank dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bank shadow state
  logic [CNT_W-1:0]     remain [NUM_SLOTS] = '{default: '0};
  logic [CNT_W-1:0]     period [NUM_SLOTS] = '{default: '0};
  logic [NUM_SLOTS-1:0] running = '0;

  tmr_resp_t  bank_out_q [$];    // responses of the request just applied
  tmr_resp_t  pending_resp_q [$];
  req_row_t   stim_q [$];
  req_row_t   dir_tbl [N_DIR];
  idle_mode_t phase_r  = PH_FREE;
  logic       hold_req = 1'b0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         errors = 0;
  int         acc_idx = 0;
  int         quiet_cycles = 0;

  task automatic update_timer_bank(input logic [REQ_W-1:0] req,
                                   input logic [SLOT_W-1:0] sid,
                                   input logic [CNT_W-1:0] ticks);
    int                fired_q [$];
    logic [STAT_W-1:0] st;
    logic [SLOT_W-1:0] fs;
    tmr_resp_t         r;
    bank_out_q.delete();
    if (req == REQ_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (running[i]) begin
          remain[i] = remain[i] - CNT_W'(1);
          if (remain[i] == '0) begin
            fired_q.push_back(i);
            if (period[i] != '0) begin
              remain[i] = period[i];
            end else begin
              running[i] = 1'b0;
            end
          end
        end
      end
      if (fired_q.size() == 0) begin
        r = {1'b0, 4'd0, ST_OK, 1'b0, |running, 1'b1};
        bank_out_q.push_back(r);
      end
      for (int k = 0; k < fired_q.size(); k++) begin
        fs = SLOT_W'(fired_q[k]);
        r = {1'b1, fs, ST_OK, running[fired_q[k]], |running, k == fired_q.size() - 1};
        bank_out_q.push_back(r);
      end
    end else if (sid >= NUM_SLOTS) begin
      r = {1'b0, 4'd0, ST_IDLE, 1'b0, |running, 1'b1};
      bank_out_q.push_back(r);
    end else begin
      st = ST_OK;
      case (req)
        REQ_START_ONCE, REQ_START_PER: begin
          if (running[sid]) begin
            st = ST_BUSY;
          end else if (ticks == '0) begin
            st = ST_ZERO;
          end else begin
            period[sid]  = (req == REQ_START_PER) ? ticks : '0;
            remain[sid]  = ticks;
            running[sid] = 1'b1;
          end
        end
        REQ_STOP: begin
          if (!running[sid]) begin
            st = ST_IDLE;
          end else begin
            remain[sid]  = '0;
            period[sid]  = '0;
            running[sid] = 1'b0;
          end
        end
        REQ_DISABLE: begin
          if (running[sid]) period[sid] = '0;
        end
        REQ_RESTART: begin
          if (!running[sid]) st = ST_IDLE;
          else if (ticks == '0) st = ST_ZERO;
          else remain[sid] = ticks;
        end
        default: ;
      endcase
      r = {1'b0, 4'd0, st, running[sid], |running, 1'b1};
      bank_out_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // scoreboard and watchdog
  always @(posedge clk) begin : mon
    tmr_resp_t got;
    tmr_resp_t want;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got = {out_tuser, out_tdata[3:0], out_tdata[5:4], out_tdata[6], out_tdata[7],
               out_tlast};
        if (pending_resp_q.size() == 0) begin
          $error("result transfer with no response pending: %h", got);
          errors++;
        end else begin
          want = pending_resp_q.pop_front();
          check_field("fired", 32'(want.fired), 32'(got.fired));
          check_field("fired_slot", 32'(want.slot), 32'(got.slot));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("slot_active", 32'(want.slot_act), 32'(got.slot_act));
          check_field("any_active", 32'(want.any_act), 32'(got.any_act));
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        update_timer_bank(in_tuser, in_tdata[3:0], in_tdata[35:4]);
        if (stim_q[acc_idx].fixed_exp) begin
          pending_resp_q.push_back(stim_q[acc_idx].want);
        end else begin
          foreach (bank_out_q[k]) pending_resp_q.push_back(bank_out_q[k]);
        end
        acc_idx++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (phase_r)
        PH_RCV_STALL: out_tready <= ($urandom_range(99) >= 52);
        PH_BOTH:      out_tready <= ($urandom_range(99) >= 24);
        default:      out_tready <= 1'b1;
      endcase
    end
  end

  initial begin : drive
    logic [REQ_W-1:0] req;
    logic [CNT_W-1:0] ticks;
    idle_mode_t       ph;
    int               pick;
    int               snd_pct;

    // req, slot, ticks, fixed, {fired, slot, status, slot_act, any_act, last}
    dir_tbl = '{
      {REQ_QUERY,      4'd0,  32'd0,          1'b1, {1'b0, 4'd0, ST_OK,   1'b0, 1'b0, 1'b1}},
      {REQ_STOP,       4'd3,  32'd0,          1'b1, {1'b0, 4'd0, ST_IDLE, 1'b0, 1'b0, 1'b1}},
      {REQ_RESTART,    4'd3,  32'd9,          1'b1, {1'b0, 4'd0, ST_IDLE, 1'b0, 1'b0, 1'b1}},
      {REQ_DISABLE,    4'd7,  32'd0,          1'b1, {1'b0, 4'd0, ST_OK,   1'b0, 1'b0, 1'b1}},
      {REQ_TICK,       4'd0,  32'd0,          1'b1, {1'b0, 4'd0, ST_OK,   1'b0, 1'b0, 1'b1}},
      {REQ_START_ONCE, 4'd0,  32'd0,          1'b1, {1'b0, 4'd0, ST_ZERO, 1'b0, 1'b0, 1'b1}},
      {REQ_START_ONCE, 4'd0,  32'd1,          1'b1, {1'b0, 4'd0, ST_OK,   1'b1, 1'b1, 1'b1}},
      {REQ_START_PER,  4'd0,  32'd5,          1'b1, {1'b0, 4'd0, ST_BUSY, 1'b1, 1'b1, 1'b1}},
      {REQ_START_PER,  4'd15, 32'd2,          1'b1, {1'b0, 4'd0, ST_OK,   1'b1, 1'b1, 1'b1}},
      {REQ_RESTART,    4'd15, 32'd0,          1'b1, {1'b0, 4'd0, ST_ZERO, 1'b1, 1'b1, 1'b1}},
      {REQ_TICK,       4'd0,  32'd0,          1'b0, NO_CHECK},
      {REQ_TICK,       4'd0,  32'd0,          1'b0, NO_CHECK},
      {REQ_DISABLE,    4'd15, 32'd0,          1'b0, NO_CHECK},
      {REQ_TICK,       4'd0,  32'd0,          1'b0, NO_CHECK},
      {REQ_TICK,       4'd0,  32'd0,          1'b0, NO_CHECK},
      {REQ_START_ONCE, 4'd5,  32'hFFFF_FFFF,  1'b1, {1'b0, 4'd0, ST_OK,   1'b1, 1'b1, 1'b1}},
      {REQ_RESTART,    4'd5,  32'hFFFF_FFFF,  1'b0, NO_CHECK},
      {REQ_START_PER,  4'd10, 32'd3,          1'b0, NO_CHECK},
      {REQ_START_PER,  4'd6,  32'd1,          1'b0, NO_CHECK},
      {REQ_RESTART,    4'd10, 32'd1,          1'b0, NO_CHECK},
      {REQ_TICK,       4'd0,  32'd0,          1'b0, NO_CHECK},
      {REQ_UNUSED,     4'd10, 32'h5A5A_A5A5,  1'b0, NO_CHECK},
      {REQ_STOP,       4'd5,  32'd0,          1'b0, NO_CHECK},
      {REQ_STOP,       4'd10, 32'd0,          1'b0, NO_CHECK},
      {REQ_STOP,       4'd6,  32'd0,          1'b0, NO_CHECK}
    };
    foreach (dir_tbl[i]) stim_q.push_back(dir_tbl[i]);

    while (stim_q.size() < N_DIR + N_RAND) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // arm the whole bank with short counts so one tick fires many slots
        for (int s = 0; s < NUM_SLOTS; s++) begin
          req = $urandom_range(1) ? REQ_START_PER : REQ_START_ONCE;
          stim_q.push_back(req_row_t'({req, 4'(s), 32'($urandom_range(1, 2)), 1'b0,
                                       NO_CHECK}));
        end
        stim_q.push_back(req_row_t'({REQ_TICK, 4'd0, 32'd0, 1'b0, NO_CHECK}));
        stim_q.push_back(req_row_t'({REQ_TICK, 4'd0, 32'd0, 1'b0, NO_CHECK}));
      end else begin
        pick = $urandom_range(99);
        if (pick < 35)      req = REQ_TICK;
        else if (pick < 50) req = REQ_START_ONCE;
        else if (pick < 65) req = REQ_START_PER;
        else if (pick < 73) req = REQ_STOP;
        else if (pick < 80) req = REQ_DISABLE;
        else if (pick < 88) req = REQ_RESTART;
        else if (pick < 95) req = REQ_QUERY;
        else                req = REQ_UNUSED;
        pick = $urandom_range(9);
        if (pick < 6)       ticks = $urandom_range(0, 4);
        else if (pick < 8)  ticks = $urandom;
        else if (pick == 8) ticks = 32'hFFFF_FFFF;
        else                ticks = $urandom_range(5, 20);
        stim_q.push_back(req_row_t'({req, 4'($urandom_range(15)), ticks, 1'b0, NO_CHECK}));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i < N_DIR) ph = PH_FREE;
      else ph = idle_mode_t'(((i - N_DIR) * 4) / (stim_q.size() - N_DIR));
      phase_r <= ph;
      if (ph == PH_RCV_STALL) hold_req <= 1'b1;
      case (ph)
        PH_SND_IDLE: snd_pct = 52;
        PH_BOTH:     snd_pct = 24;
        default:     snd_pct = 0;
      endcase
      if ($urandom_range(99) < snd_pct) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= stim_q[i].req;
      in_tdata  <= {4'b0, stim_q[i].ticks, stim_q[i].sid};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending_resp_q.size() != 0) @(posedge clk);
    repeat (2 * NUM_SLOTS + 8) @(posedge clk);
    if (errors == 0 && pending_resp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
